// ===== src/gif_pkg.sv =====
// ============================================================================
// gif_pkg
// Shared types and constants for the glob include/exclude filter.
// ============================================================================
`default_nettype none

package gif_pkg;

    localparam int NUM_PATTERNS_DEF = 6;
    localparam int PATTERN_LEN_DEF  = 8;
    localparam int BYTE_W           = 8;
    localparam int CFG_INDEX_W      = 4;

    localparam logic [BYTE_W-1:0] STAR_CODE  = 8'h2A;
    localparam logic [BYTE_W-1:0] QMARK_CODE = 8'h3F;
    localparam logic [BYTE_W-1:0] NUL_CODE   = 8'h00;

    // Signals handed from one position cell to the next.
    typedef struct packed {
        logic exists;   // this position lies within the pattern
        logic pass;     // reached through a star of the previous position
        logic adv;      // previous position consumed the current byte
    } gif_link_t;

    // Update control shared by every cell.
    typedef struct packed {
        logic step;     // advance on a nonzero name byte
        logic restart;  // return to the start position after an end word
    } gif_ctrl_t;

endpackage

`default_nettype wire

// ===== src/gif_cell.sv =====
// ============================================================================
// gif_cell
// One pattern position: holds its active bit and passes closure and
// advance results to the next position.
// ============================================================================
`default_nettype none

module gif_cell
    import gif_pkg::*;
#(
    parameter logic START = 1'b0
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gif_ctrl_t         ctrl,
    input  wire logic [BYTE_W-1:0] pat_byte,
    input  wire logic [BYTE_W-1:0] char_code,
    input  wire gif_link_t         link_in,
    output gif_link_t              link_out,
    output logic                   hit
);

    logic active_reg;
    logic active_next;
    logic closed;

    assign closed = link_in.exists & (active_reg | link_in.pass);

    assign link_out.exists = link_in.exists & (pat_byte != NUL_CODE);
    assign link_out.pass   = closed & (pat_byte == STAR_CODE);
    assign link_out.adv    = closed & (pat_byte != STAR_CODE)
                           & ((pat_byte == char_code) | (pat_byte == QMARK_CODE));
    assign hit             = closed & (pat_byte == NUL_CODE);

    always_comb
    begin
        active_next = active_reg;
        if (ctrl.restart)
        begin
            active_next = START;
        end
        else if (ctrl.step)
        begin
            active_next = link_out.pass | link_in.adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= START;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/gif_matcher.sv =====
// ============================================================================
// gif_matcher
// One glob pattern: a row of position cells plus the final position.
// ============================================================================
`default_nettype none

module gif_matcher
    import gif_pkg::*;
#(
    parameter int PATTERN_LEN = PATTERN_LEN_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gif_ctrl_t                     ctrl,
    input  wire logic [BYTE_W*PATTERN_LEN-1:0] pattern_word,
    input  wire logic [BYTE_W-1:0]             char_code,
    output logic                               present,
    output logic                               matched
);

    gif_link_t              link [PATTERN_LEN+1];
    logic [PATTERN_LEN-1:0] hits;
    logic                   final_reg;
    logic                   final_next;
    logic                   final_closed;

    assign link[0] = '{exists: 1'b1, pass: 1'b0, adv: 1'b0};

    for (genvar j = 0; j < PATTERN_LEN; j++)
    begin : g_cell
        gif_cell #(
            .START (j == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .pat_byte  (pattern_word[BYTE_W*j +: BYTE_W]),
            .char_code (char_code),
            .link_in   (link[j]),
            .link_out  (link[j+1]),
            .hit       (hits[j])
        );
    end

    assign final_closed = link[PATTERN_LEN].exists
                        & (final_reg | link[PATTERN_LEN].pass);

    always_comb
    begin
        final_next = final_reg;
        if (ctrl.restart)
        begin
            final_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            final_next = link[PATTERN_LEN].adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            final_reg <= 1'b0;
        end
        else
        begin
            final_reg <= final_next;
        end
    end

    assign present = (pattern_word[BYTE_W-1:0] != NUL_CODE);
    assign matched = present & ((|hits) | final_closed);

endmodule

`default_nettype wire

// ===== src/glob_include_exclude_filter.sv =====
// A result is registered into the output register when its end word is accepted.
// One word per cycle while in_ready is high; all pattern positions update in parallel.
// A pending result does not stop input while the output side takes it in the same cycle.
// Reset clears all patterns and the exclude mask, returns every pattern to its start
// position and clears the output valid flag; the result fields are not reset.
// ============================================================================
// glob_include_exclude_filter
// Streams file names byte by byte against a set of glob patterns and gives
// one include decision per name.
// ============================================================================
`default_nettype none

module glob_include_exclude_filter
    import gif_pkg::*;
#(
    parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
    parameter int PATTERN_LEN  = PATTERN_LEN_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [BYTE_W*PATTERN_LEN-1:0] cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [BYTE_W-1:0]             char_code,
    input  wire logic                          is_end,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               included,
    output logic [NUM_PATTERNS-1:0]            match_mask
);

    localparam int WORD_W = BYTE_W * PATTERN_LEN;

    logic [WORD_W-1:0]       pattern_reg [NUM_PATTERNS];
    logic [NUM_PATTERNS-1:0] exclude_reg;
    logic [NUM_PATTERNS-1:0] present;
    logic [NUM_PATTERNS-1:0] matched;
    gif_ctrl_t               ctrl;
    logic                    in_fire;
    logic                    end_fire;
    logic                    any_include;
    logic                    include_hit;
    logic                    exclude_hit;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    included_reg;
    logic [NUM_PATTERNS-1:0] match_mask_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign end_fire = in_fire && is_end;

    assign ctrl.step    = in_fire && !is_end && (char_code != NUL_CODE);
    assign ctrl.restart = end_fire;

    for (genvar p = 0; p < NUM_PATTERNS; p++)
    begin : g_pat
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pattern_reg[p] <= '0;
            end
            else if (cfg_wr_en && (cfg_index == CFG_INDEX_W'(p)))
            begin
                pattern_reg[p] <= cfg_wdata;
            end
        end

        gif_matcher #(
            .PATTERN_LEN (PATTERN_LEN)
        ) u_matcher (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .pattern_word (pattern_reg[p]),
            .char_code    (char_code),
            .present      (present[p]),
            .matched      (matched[p])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exclude_reg <= '0;
        end
        else if (cfg_wr_en && (cfg_index == CFG_INDEX_W'(NUM_PATTERNS)))
        begin
            exclude_reg <= cfg_wdata[NUM_PATTERNS-1:0];
        end
    end

    assign any_include = |(present & ~exclude_reg);
    assign include_hit = |(matched & ~exclude_reg);
    assign exclude_hit = |(matched & exclude_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (end_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_fire)
        begin
            included_reg   <= !exclude_hit && (!any_include || include_hit);
            match_mask_reg <= matched;
        end
    end

    assign out_valid  = out_valid_reg;
    assign included   = included_reg;
    assign match_mask = match_mask_reg;

endmodule

`default_nettype wire

// ===== src/gif_checker.sv =====
// ============================================================================
// gif_checker
// Port-level checks on the glob include/exclude filter.
// ============================================================================
`default_nettype none

module gif_checker
    import gif_pkg::*;
#(
    parameter int NUM_PATTERNS = NUM_PATTERNS_DEF
)
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    is_end,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic                    included,
    input wire logic [NUM_PATTERNS-1:0] match_mask
);

    // The block takes words whenever no result is pending.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output register");

    // Every accepted end word yields a result in the next cycle.
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && is_end |=> out_valid)
        else $error("end word gave no result");

    // A byte word never creates a result by itself.
    a_byte_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !is_end && (!out_valid || out_ready) |=> !out_valid)
        else $error("result appeared without an end word");

    // A stalled result holds its value.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(included) && $stable(match_mask))
        else $error("pending result changed");

endmodule

bind glob_include_exclude_filter gif_checker #(
    .NUM_PATTERNS (NUM_PATTERNS)
) u_gif_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .is_end     (is_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .included   (included),
    .match_mask (match_mask)
);

`default_nettype wire

// ===== test/tb_glob_include_exclude_filter.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_glob_include_exclude_filter
// Streams file names into the filter and checks every decision against a
// behavioral copy of the per-pattern position sets, under directed pattern
// cases, extreme register settings and randomly drawn pattern sets.
// ============================================================================

module tb_glob_include_exclude_filter;

    import gif_pkg::*;

    localparam int NP = NUM_PATTERNS_DEF;
    localparam int PL = PATTERN_LEN_DEF;
    localparam int WORD_W = BYTE_W * PL;

    localparam logic [CFG_INDEX_W-1:0] EXCLUDE_MASK_REG = CFG_INDEX_W'(NP);
    localparam logic [CFG_INDEX_W-1:0] FIRST_UNUSED_REG = CFG_INDEX_W'(NP + 1);
    localparam logic [CFG_INDEX_W-1:0] LAST_UNUSED_REG  = '1;

    localparam logic [BYTE_W-1:0] CHAR_A   = "a";
    localparam logic [BYTE_W-1:0] CHAR_B   = "b";
    localparam logic [BYTE_W-1:0] CHAR_C   = "c";
    localparam logic [BYTE_W-1:0] CHAR_DOT = ".";

    typedef struct packed {
        logic          included;
        logic [NP-1:0] match_mask;
    } verdict_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WORD_W-1:0]      cfg_wdata;
    logic                   in_valid;
    logic                   in_ready;
    logic [BYTE_W-1:0]      char_code;
    logic                   is_end;
    logic                   out_valid;
    logic                   out_ready;
    logic                   included;
    logic [NP-1:0]          match_mask;

    logic [WORD_W-1:0] pattern_word [NP];
    logic [NP-1:0]     exclude_bits;
    logic [PL:0]       live_positions [NP];
    verdict_t          verdicts_due [$];

    int mismatches     = 0;
    int words_sent     = 0;
    int names_checked  = 0;
    int settings_used  = 0;
    int in_gap_odds    = 0;
    int out_stall_odds = 0;
    bit calm           = 1'b0;

    glob_include_exclude_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .is_end     (is_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .included   (included),
        .match_mask (match_mask)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Filter prediction
    // ------------------------------------------------------------------------

    function automatic int pattern_length(input int p);
        int n;
        n = 0;
        while (n < PL && pattern_word[p][BYTE_W*n +: BYTE_W] != NUL_CODE)
            n++;
        return n;
    endfunction

    function automatic logic [PL:0] star_fill(input int p, input logic [PL:0] set);
        logic [31:0] keep;
        int n;
        n = pattern_length(p);
        keep = (32'd1 << (n + 1)) - 32'd1;
        set = set & keep[PL:0];
        for (int j = 0; j < n; j++)
        begin
            if (set[j] && pattern_word[p][BYTE_W*j +: BYTE_W] == STAR_CODE)
                set[j+1] = 1'b1;
        end
        return set;
    endfunction

    function automatic logic [PL:0] consume_byte(input int p, input logic [PL:0] set,
                                                 input logic [BYTE_W-1:0] c);
        logic [PL:0] next;
        logic [BYTE_W-1:0] b;
        int n;
        n = pattern_length(p);
        next = '0;
        set = star_fill(p, set);
        for (int j = 0; j < n; j++)
        begin
            b = pattern_word[p][BYTE_W*j +: BYTE_W];
            if (set[j])
            begin
                if (b == STAR_CODE)
                    next[j] = 1'b1;
                else if (b == QMARK_CODE || b == c)
                    next[j+1] = 1'b1;
            end
        end
        return next;
    endfunction

    function automatic void close_name();
        verdict_t v;
        logic [PL:0] set;
        logic any_include;
        logic include_hit;
        logic exclude_hit;
        int n;
        v = '0;
        any_include = 1'b0;
        include_hit = 1'b0;
        exclude_hit = 1'b0;
        for (int p = 0; p < NP; p++)
        begin
            n = pattern_length(p);
            set = star_fill(p, live_positions[p]);
            live_positions[p] = 1;
            if (n != 0)
            begin
                if (set[n])
                    v.match_mask[p] = 1'b1;
                if (exclude_bits[p])
                    exclude_hit = exclude_hit | set[n];
                else
                begin
                    any_include = 1'b1;
                    include_hit = include_hit | set[n];
                end
            end
        end
        v.included = !exclude_hit && (!any_include || include_hit);
        verdicts_due.push_back(v);
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    task automatic put_word(input logic [BYTE_W-1:0] c, input logic e);
        in_valid  <= 1'b1;
        char_code <= c;
        is_end    <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (e)
        begin
            close_name();
            words_sent++;
        end
        else if (c != NUL_CODE)
        begin
            for (int p = 0; p < NP; p++)
                live_positions[p] = consume_byte(p, live_positions[p], c);
            words_sent++;
        end
        if (!calm && in_gap_odds != 0 && $urandom_range(0, 15) < in_gap_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        if (idx < NP)
            pattern_word[idx] = data;
        else if (idx == EXCLUDE_MASK_REG)
            exclude_bits = data[NP-1:0];
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic put_char(input logic [BYTE_W-1:0] c);
        if ($urandom_range(0, 19) == 0)
            put_word(NUL_CODE, 1'b0);
        put_word(c, 1'b0);
    endtask

    task automatic send_text(input string s);
        for (int j = 0; j < s.len(); j++)
            put_word(s[j], 1'b0);
        put_word(BYTE_W'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [WORD_W-1:0] pack_text(input string s);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int j = 0; j < s.len() && j < PL; j++)
            w[BYTE_W*j +: BYTE_W] = s[j];
        return w;
    endfunction

    function automatic logic [BYTE_W-1:0] random_name_byte();
        case ($urandom_range(0, 7))
            0, 1: return CHAR_A;
            2: return CHAR_B;
            3: return CHAR_DOT;
            4: return CHAR_C;
            default: return BYTE_W'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] random_pattern_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return STAR_CODE;
            3, 4: return QMARK_CODE;
            5: return CHAR_A;
            6: return CHAR_B;
            7: return CHAR_DOT;
            8: return CHAR_C;
            default: return BYTE_W'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_pattern();
        logic [WORD_W-1:0] w;
        int n;
        w = '0;
        n = $urandom_range(1, PL);
        if ($urandom_range(0, 7) != 0)
        begin
            for (int j = 0; j < n; j++)
                w[BYTE_W*j +: BYTE_W] = random_pattern_byte();
            // Bytes past the terminating zero must be ignored by the filter.
            if (n < PL - 1 && $urandom_range(0, 3) == 0)
                for (int j = n + 1; j < PL; j++)
                    w[BYTE_W*j +: BYTE_W] = BYTE_W'($urandom_range(0, 255));
        end
        return w;
    endfunction

    task automatic send_name_like(input int p);
        logic [BYTE_W-1:0] b;
        int n;
        n = pattern_length(p);
        for (int j = 0; j < n; j++)
        begin
            b = pattern_word[p][BYTE_W*j +: BYTE_W];
            if ($urandom_range(0, 24) != 0)
            begin
                if (b == STAR_CODE)
                    repeat ($urandom_range(0, 3)) put_char(random_name_byte());
                else if (b == QMARK_CODE)
                    put_char(random_name_byte());
                else if ($urandom_range(0, 24) == 0)
                    put_char(random_name_byte());
                else
                    put_char(b);
            end
        end
        if ($urandom_range(0, 15) == 0)
            put_char(random_name_byte());
        put_word(BYTE_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_random_name();
        repeat ($urandom_range(0, 10)) put_char(random_name_byte());
        put_word(BYTE_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic run_names(input int count);
        int stop_at;
        int p;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            p = $urandom_range(0, NP - 1);
            if ($urandom_range(0, 4) != 0 && pattern_length(p) != 0)
                send_name_like(p);
            else
                send_random_name();
        end
    endtask

    task automatic apply_setting(input logic [WORD_W-1:0] words [NP], input logic [NP-1:0] mask);
        settle();
        for (int p = 0; p < NP; p++)
            write_reg(CFG_INDEX_W'(p), words[p]);
        write_reg(EXCLUDE_MASK_REG, WORD_W'(mask));
        in_gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        out_stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!calm && out_stall_odds != 0 && $urandom_range(0, 15) < out_stall_odds)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_result
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual included=%0b match_mask=%h",
                         $time, included, match_mask);
                mismatches++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                names_checked++;
                if (included !== want.included)
                begin
                    $display("%0t: included expected %0b actual %0b",
                             $time, want.included, included);
                    mismatches++;
                end
                if (match_mask !== want.match_mask)
                begin
                    $display("%0t: match_mask expected %h actual %h",
                             $time, want.match_mask, match_mask);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_power_on_defaults();
        send_text("");
        put_word(CHAR_A, 1'b0);
        put_word(NUL_CODE, 1'b0);
        put_word(CHAR_B, 1'b0);
        put_word(8'hFF, 1'b1);
    endtask

    task automatic test_pattern_features();
        settle();
        write_reg(0, pack_text("*.txt"));
        write_reg(1, pack_text("?"));
        write_reg(2, pack_text("**"));
        write_reg(3, pack_text("abcdefgh"));
        write_reg(4, WORD_W'({CHAR_B, CHAR_A, NUL_CODE, CHAR_X}));
        write_reg(5, WORD_W'({8'h01, STAR_CODE, QMARK_CODE, 8'hFF}));
        write_reg(EXCLUDE_MASK_REG, WORD_W'(6'b110000));
        write_reg(FIRST_UNUSED_REG, '1);
        write_reg(LAST_UNUSED_REG, '1);
        send_text("");
        send_text("a.txt");
        send_text("x");
        send_text("abcdefgh");
        put_word(8'hFF, 1'b0);
        put_word(8'h80, 1'b0);
        put_word(8'h7A, 1'b0);
        put_word(8'h01, 1'b0);
        put_word(NUL_CODE, 1'b1);
        settle();
        write_reg(2, '0);
        send_text("ab");
    endtask

    localparam logic [BYTE_W-1:0] CHAR_X = "x";

    task automatic test_rewrite_mid_name();
        settle();
        write_reg(0, pack_text("ab*"));
        for (int p = 1; p < NP; p++)
            write_reg(CFG_INDEX_W'(p), '0);
        write_reg(EXCLUDE_MASK_REG, '0);
        put_word(CHAR_A, 1'b0);
        put_word(CHAR_B, 1'b0);
        settle();
        write_reg(0, pack_text("a"));
        put_word(NUL_CODE, 1'b1);
        settle();
        write_reg(0, pack_text("ab*"));
        put_word(CHAR_A, 1'b0);
        put_word(CHAR_B, 1'b0);
        settle();
        write_reg(0, pack_text("??"));
        put_word(CHAR_C, 1'b1);
    endtask

    task automatic test_extreme_settings();
        logic [WORD_W-1:0] words [NP];
        for (int p = 0; p < NP; p++)
            words[p] = '0;
        apply_setting(words, '1);
        run_names(80);
        for (int p = 0; p < NP; p++)
            words[p] = '1;
        apply_setting(words, '0);
        run_names(80);
        apply_setting(words, '1);
        run_names(80);
    endtask

    task automatic test_random_settings();
        logic [WORD_W-1:0] words [NP];
        logic [NP-1:0] mask;
        for (int k = 0; k < 6; k++)
        begin
            for (int p = 0; p < NP; p++)
                words[p] = random_pattern();
            case ($urandom_range(0, 3))
                0: mask = '0;
                1: mask = '1;
                default: mask = NP'($urandom_range(0, (1 << NP) - 1));
            endcase
            apply_setting(words, mask);
            if (k == 5)
                calm = 1'b1;
            run_names(170);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_code = '0;
        is_end    = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        for (int p = 0; p < NP; p++)
        begin
            pattern_word[p]   = '0;
            live_positions[p] = 1;
        end
        exclude_bits = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_defaults();
        test_pattern_features();
        test_rewrite_mid_name();
        test_extreme_settings();
        test_random_settings();

        settle();
        repeat (5) @(posedge clk);
        $display("Streamed %0d name bytes and end words under %0d register settings.",
                 words_sent, settings_used);
        $display("Checked %0d filter decisions, %0d field mismatches.",
                 names_checked, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
src/gif_pkg.sv
src/gif_cell.sv
src/gif_matcher.sv
src/glob_include_exclude_filter.sv
src/gif_checker.sv
test/tb_glob_include_exclude_filter.sv
